// ===== rtl/core/mfek_pkg.sv =====
package mfek_pkg;

  localparam int Nodes   = 64;
  localparam int NodeW   = $clog2(Nodes);
  localparam int CntW    = NodeW + 1;
  localparam int ResAddrW = 2 * NodeW;
  localparam int CapW    = 16;
  localparam int ResW    = 17;
  localparam int FlowW   = 22;

  localparam logic [ResW-1:0]  ResMax  = {ResW{1'b1}};
  localparam logic [FlowW-1:0] FlowMax = {FlowW{1'b1}};

  // item opcodes
  localparam logic OpAddEdge = 1'b0;
  localparam logic OpRun     = 1'b1;

  typedef enum logic [1:0] {
    ALU_MIN      = 2'd0,
    ALU_SUB_SAT  = 2'd1,
    ALU_ADD_RES  = 2'd2,
    ALU_ADD_FLOW = 2'd3
  } alu_op_e;

endpackage

// ===== rtl/core/max_flow_edmonds_karp.sv =====
// channel   | direction | transfer condition     | payload
// ----------+-----------+------------------------+----------------------------------------
// command   | in        | start_i && !busy_o     | op, edge_from/to, edge_capacity, nodes
// result    | out       | valid_o (one cycle)    | max_flow_o
//
// after reset a clearing pass zeroes every entry of the residual matrix; busy stays high until it ends
// an add-edge item writes its capacity straight into the residual matrix; busy stays low
// a run does repeated bfs passes: each dequeued node is fetched from the queue
// and scanned, one residual ram read per neighbour, then the read pipeline is
// drained; each augment step reads a parent and updates the forward and reverse entries
// the result strobe is one cycle; the receiver cannot stall it
module max_flow_edmonds_karp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         op_i,
  input  logic [5:0]                   edge_from_i,
  input  logic [5:0]                   edge_to_i,
  input  logic [15:0]                  edge_capacity_i,
  input  logic [5:0]                   source_node_i,
  input  logic [5:0]                   sink_node_i,
  output logic                         valid_o,
  output logic [mfek_pkg::FlowW-1:0]   max_flow_o
);

  localparam int NodeW = mfek_pkg::NodeW;
  localparam int CntW  = mfek_pkg::CntW;
  localparam int ResW  = mfek_pkg::ResW;
  localparam int FlowW = mfek_pkg::FlowW;
  localparam int AW    = mfek_pkg::ResAddrW;
  localparam int QW    = NodeW + ResW;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_INIT   = 11'b00000000100,
    ST_HEAD   = 11'b00000001000,
    ST_HEADW  = 11'b00000010000,
    ST_SCAN   = 11'b00000100000,
    ST_FLOW   = 11'b00001000000,
    ST_AUGP   = 11'b00010000000,
    ST_AUGPW  = 11'b00100000000,
    ST_AUGFR  = 11'b01000000000,
    ST_AUGFW  = 11'b10000000000
  } state_e;

  // reverse write step shares an encoding slot via a flag
  state_e               state_q, state_d;
  logic                 rev_q, rev_d;
  logic [AW:0]          clr_q, clr_d;
  logic [NodeW-1:0]     src_q, src_d, snk_q, snk_d;
  logic [NodeW-1:0]     cur_q, cur_d, prev_q, prev_d;
  logic [ResW-1:0]      bn_q, bn_d, f_q, f_d;
  logic [CntW-1:0]      head_q, head_d, tail_q, tail_d, sc_q, sc_d, steps_q, steps_d;
  logic                 pv_q, pv_d;
  logic [NodeW-1:0]     pnx_q, pnx_d;
  logic [mfek_pkg::Nodes-1:0] seen_q, seen_d;
  logic [FlowW-1:0]     flow_q, flow_d;
  logic                 valid_q, valid_d;

  // residual ram
  logic                 res_we;
  logic [AW-1:0]        res_waddr, res_raddr;
  logic [ResW-1:0]      res_wdata, res_rdata;
  // bfs queue ram: node and bottleneck
  logic                 q_we;
  logic [NodeW-1:0]     q_waddr, q_raddr;
  logic [QW-1:0]        q_wdata, q_rdata;
  // parent ram
  logic                 p_we;
  logic [NodeW-1:0]     p_waddr, p_raddr;
  logic [NodeW-1:0]     p_wdata, p_rdata;
  // shared alu
  mfek_pkg::alu_op_e    alu_op;
  logic [FlowW-1:0]     alu_a, alu_y;
  logic [ResW-1:0]      alu_b;

  logic                 accept;
  logic                 hit;

  mfek_ram #(.Width(ResW), .Depth(mfek_pkg::Nodes * mfek_pkg::Nodes)) u_res_ram (
    .clk_i, .we_i(res_we), .waddr_i(res_waddr), .wdata_i(res_wdata),
    .raddr_i(res_raddr), .rdata_o(res_rdata)
  );

  mfek_ram #(.Width(QW), .Depth(mfek_pkg::Nodes)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  mfek_ram #(.Width(NodeW), .Depth(mfek_pkg::Nodes)) u_parent_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  mfek_alu u_alu (.op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .y_o(alu_y));

  assign busy_o     = (state_q != ST_IDLE);
  assign accept     = start_i && !busy_o;
  assign valid_o    = valid_q;
  assign max_flow_o = flow_q;

  // a scanned neighbour with residual left that is not seen yet
  assign hit = pv_q && !seen_q[pnx_q] && (res_rdata != '0);

  always_comb begin
    state_d = state_q;
    rev_d   = rev_q;
    clr_d   = clr_q;
    src_d   = src_q;
    snk_d   = snk_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    bn_d    = bn_q;
    f_d     = f_q;
    head_d  = head_q;
    tail_d  = tail_q;
    sc_d    = sc_q;
    steps_d = steps_q;
    pv_d    = 1'b0;
    pnx_d   = pnx_q;
    seen_d  = seen_q;
    flow_d  = flow_q;
    valid_d = 1'b0;

    res_we    = 1'b0;
    res_waddr = '0;
    res_wdata = '0;
    res_raddr = '0;
    q_we      = 1'b0;
    q_waddr   = tail_q[NodeW-1:0];
    q_wdata   = '0;
    q_raddr   = head_q[NodeW-1:0];
    p_we      = 1'b0;
    p_waddr   = pnx_q;
    p_wdata   = cur_q;
    p_raddr   = cur_q;
    alu_op    = mfek_pkg::ALU_MIN;
    alu_a     = FlowW'(bn_q);
    alu_b     = res_rdata;

    case (state_q)
      ST_CLEAR: begin
        res_we    = 1'b1;
        res_waddr = clr_q[AW-1:0];
        clr_d     = clr_q + 1'b1;
        if (clr_q[AW-1:0] == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_i == mfek_pkg::OpAddEdge) begin
            res_we    = 1'b1;
            res_waddr = {edge_from_i, edge_to_i};
            res_wdata = ResW'(edge_capacity_i);
          end else begin
            src_d  = source_node_i;
            snk_d  = sink_node_i;
            flow_d = '0;
            if (source_node_i == sink_node_i) begin
              valid_d = 1'b1;
              state_d = ST_FLOW;
              rev_d   = 1'b1;
            end else begin
              state_d = ST_INIT;
            end
          end
        end
      end
      ST_INIT: begin
        // fresh search: only the source is seen
        seen_d              = '0;
        seen_d[src_q]       = 1'b1;
        q_we                = 1'b1;
        q_waddr             = '0;
        q_wdata             = {src_q, mfek_pkg::ResMax};
        head_d              = '0;
        tail_d              = CntW'(1);
        state_d             = ST_HEAD;
      end
      ST_HEAD: begin
        if (head_q < tail_q) begin
          state_d = ST_HEADW;
        end else begin
          // no augmenting path left
          valid_d = 1'b1;
          rev_d   = 1'b1;
          state_d = ST_FLOW;
        end
      end
      ST_HEADW: begin
        cur_d   = q_rdata[QW-1:ResW];
        bn_d    = q_rdata[ResW-1:0];
        head_d  = head_q + 1'b1;
        sc_d    = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // issue one residual read per cycle, judge the previous one
        res_raddr = {cur_q, sc_q[NodeW-1:0]};
        if (sc_q < CntW'(mfek_pkg::Nodes)) begin
          pv_d  = 1'b1;
          pnx_d = sc_q[NodeW-1:0];
          sc_d  = sc_q + 1'b1;
        end
        if (hit) begin
          seen_d[pnx_q] = 1'b1;
          p_we          = 1'b1;
          if (pnx_q == snk_q) begin
            f_d     = alu_y[ResW-1:0];
            pv_d    = 1'b0;
            rev_d   = 1'b0;
            state_d = ST_FLOW;
          end else if (tail_q < CntW'(mfek_pkg::Nodes)) begin
            q_we    = 1'b1;
            q_wdata = {pnx_q, alu_y[ResW-1:0]};
            tail_d  = tail_q + 1'b1;
          end
        end else if (!pv_q && sc_q == CntW'(mfek_pkg::Nodes)) begin
          state_d = ST_HEAD;
        end
      end
      ST_FLOW: begin
        if (rev_q) begin
          // result strobe cycle
          rev_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          alu_op  = mfek_pkg::ALU_ADD_FLOW;
          alu_a   = flow_q;
          alu_b   = f_q;
          flow_d  = alu_y;
          cur_d   = snk_q;
          steps_d = '0;
          state_d = ST_AUGP;
        end
      end
      ST_AUGP: begin
        if (cur_q == src_q || steps_q == CntW'(mfek_pkg::Nodes)) begin
          state_d = ST_INIT;
        end else begin
          p_raddr = cur_q;
          state_d = ST_AUGPW;
        end
      end
      ST_AUGPW: begin
        prev_d  = p_rdata;
        rev_d   = 1'b0;
        state_d = ST_AUGFR;
      end
      ST_AUGFR: begin
        res_raddr = {prev_q, cur_q};
        state_d   = ST_AUGFW;
      end
      ST_AUGFW: begin
        if (!rev_q) begin
          // forward entry loses the path flow, then fetch the reverse entry
          alu_op    = mfek_pkg::ALU_SUB_SAT;
          alu_a     = FlowW'(res_rdata);
          alu_b     = f_q;
          res_we    = 1'b1;
          res_waddr = {prev_q, cur_q};
          res_wdata = alu_y[ResW-1:0];
          res_raddr = {cur_q, prev_q};
          rev_d     = 1'b1;
        end else begin
          alu_op    = mfek_pkg::ALU_ADD_RES;
          alu_a     = FlowW'(res_rdata);
          alu_b     = f_q;
          res_we    = 1'b1;
          res_waddr = {cur_q, prev_q};
          res_wdata = alu_y[ResW-1:0];
          rev_d     = 1'b0;
          cur_d     = prev_q;
          steps_d   = steps_q + 1'b1;
          state_d   = ST_AUGP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      rev_q   <= 1'b0;
      clr_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      sc_q    <= '0;
      steps_q <= '0;
      pv_q    <= 1'b0;
      seen_q  <= '0;
      flow_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rev_q   <= rev_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      sc_q    <= sc_d;
      steps_q <= steps_d;
      pv_q    <= pv_d;
      seen_q  <= seen_d;
      flow_q  <= flow_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    snk_q  <= snk_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    bn_q   <= bn_d;
    f_q    <= f_d;
    pnx_q  <= pnx_d;
  end

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= CntW'(mfek_pkg::Nodes)))
    else $error("bfs queue pointers out of order");

  a_same_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == mfek_pkg::OpRun && source_node_i == sink_node_i)
      |=> (valid_o && max_flow_o == '0))
    else $error("run with source equal to sink must give zero at once");

  a_busy_on_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe while idle");
`endif

endmodule

// ===== rtl/core/mfek_ram.sv =====
module mfek_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/mfek_alu.sv =====
module mfek_alu (
  input  mfek_pkg::alu_op_e              op_i,
  input  logic [mfek_pkg::FlowW-1:0]     a_i,
  input  logic [mfek_pkg::ResW-1:0]      b_i,
  output logic [mfek_pkg::FlowW-1:0]     y_o
);

  logic [mfek_pkg::FlowW:0]   sum;
  logic [mfek_pkg::FlowW-1:0] b_ext;

  assign b_ext = mfek_pkg::FlowW'(b_i);
  assign sum   = {1'b0, a_i} + {1'b0, b_ext};

  always_comb begin
    case (op_i)
      mfek_pkg::ALU_MIN:     y_o = (a_i < b_ext) ? a_i : b_ext;
      mfek_pkg::ALU_SUB_SAT: y_o = (a_i >= b_ext) ? (a_i - b_ext) : '0;
      mfek_pkg::ALU_ADD_RES: begin
        y_o = (sum > (mfek_pkg::FlowW+1)'(mfek_pkg::ResMax)) ?
              mfek_pkg::FlowW'(mfek_pkg::ResMax) : sum[mfek_pkg::FlowW-1:0];
      end
      mfek_pkg::ALU_ADD_FLOW: begin
        y_o = sum[mfek_pkg::FlowW] ? mfek_pkg::FlowMax : sum[mfek_pkg::FlowW-1:0];
      end
      default: y_o = '0;
    endcase
  end

endmodule
